FILE: design/brrs_pkg.sv
// ----------------------------------------------------------------------------
// brrs_pkg
// Shared constants, register codes and helper functions for the Bloch
// rotation and relaxation pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package brrs_pkg;

   // angles in Q.30
   localparam logic [32:0] TWO_PI_Q30   = 33'd6746518852;
   localparam logic [31:0] PI_Q30       = 32'd3373259426;
   localparam logic [30:0] HALF_PI_Q30  = 31'd1686629713;
   localparam logic [29:0] CORDIC_K_Q30 = 30'd652032874;
   localparam logic [30:0] Q30_ONE      = 31'd1073741824;

   localparam int ATAN_ENTRIES         = 24;
   localparam int CORDIC_STEPS_DEFAULT = 16;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 24;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_FIELD_GAIN  = 2'd0,
      CSR_RELAX_LONG  = 2'd1,
      CSR_RELAX_TRANS = 2'd2
   } csr_addr_type;

   localparam logic [23:0] FIELD_GAIN_RESET  = 24'd65536;
   localparam logic [15:0] RELAX_LONG_RESET  = 16'd0;
   localparam logic [15:0] RELAX_TRANS_RESET = 16'd32768;

   // floor(atan(2^-i) * 2^30)
   function automatic logic [29:0] atan_q30(input logic [4:0] idx);
      logic [29:0] val;
      case (idx)
         5'd0:    val = 30'd843314856;
         5'd1:    val = 30'd497837829;
         5'd2:    val = 30'd263043836;
         5'd3:    val = 30'd133525158;
         5'd4:    val = 30'd67021686;
         5'd5:    val = 30'd33543515;
         5'd6:    val = 30'd16775850;
         5'd7:    val = 30'd8388437;
         5'd8:    val = 30'd4194282;
         5'd9:    val = 30'd2097149;
         5'd10:   val = 30'd1048575;
         5'd11:   val = 30'd524287;
         5'd12:   val = 30'd262143;
         5'd13:   val = 30'd131071;
         5'd14:   val = 30'd65535;
         5'd15:   val = 30'd32767;
         5'd16:   val = 30'd16383;
         5'd17:   val = 30'd8191;
         5'd18:   val = 30'd4095;
         5'd19:   val = 30'd2047;
         5'd20:   val = 30'd1023;
         5'd21:   val = 30'd511;
         5'd22:   val = 30'd255;
         5'd23:   val = 30'd127;
         default: val = 30'd0;
      endcase
      return val;
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
      logic signed [15:0] res;
      if (v > 48'sd32767) begin
         res = 16'sh7fff;
      end else if (v < -48'sd32768) begin
         res = 16'sh8000;
      end else begin
         res = v[15:0];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

FILE: design/bloch_rotation_relaxation_step.sv
// ----------------------------------------------------------------------------
// bloch_rotation_relaxation_step
// Rotates a magnetization vector about a scaled field vector and applies
// T1/T2 relaxation in a deep pipeline, one vector per cycle unless stalled.
//
// Usage:
//   req_* carries one spin/time-point transaction: field, magnetization and an
//   optional increment (incr_valid). rsp_* returns the relaxed rotated vector,
//   saturated to Q2.14, one response per request, in order.
//   Both channels use valid/stall; a transaction moves when valid is high and
//   stall is low. csr_* writes field_gain, relax_long_factor and
//   relax_trans_factor; write them only while the pipeline is empty.
//   The pipeline holds a 32-stage square root, a 22-stage reduction modulo
//   2*pi, one stage per CORDIC iteration and seven product/relaxation stages;
//   the 31-stage normalizing division runs beside the reduction and CORDIC.
//   One transaction is accepted per cycle while no response is stalled. When
//   rsp_stall holds a pending response the whole pipeline freezes and
//   req_stall rises in the same cycle; nothing is dropped or repeated.
//   Reset clears every stage valid and restores the register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bloch_rotation_relaxation_step
   import brrs_pkg::*;
#(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEFAULT
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_stall,
   input  wire  signed [15:0]         req_field_x,
   input  wire  signed [15:0]         req_field_y,
   input  wire  signed [15:0]         req_field_z,
   input  wire  signed [15:0]         req_mag_x,
   input  wire  signed [15:0]         req_mag_y,
   input  wire  signed [15:0]         req_mag_z,
   input  wire                        req_incr_valid,
   input  wire  signed [15:0]         req_incr_x,
   input  wire  signed [15:0]         req_incr_y,
   input  wire  signed [15:0]         req_incr_z,
   input  wire         [15:0]         req_incr_scale,
   output logic                       rsp_valid,
   input  wire                        rsp_stall,
   output logic signed [15:0]         rsp_out_x,
   output logic signed [15:0]         rsp_out_y,
   output logic signed [15:0]         rsp_out_z,
   input  wire                        csr_wr_en,
   input  wire         [CSR_ADDR_W-1:0] csr_addr,
   input  wire         [CSR_DATA_W-1:0] csr_wdata
);

   localparam int NSTEP     = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
   localparam int SQ_STEPS  = 32;
   localparam int MOD_STEPS = 22;
   localparam int DIV_STEPS = 31;
   localparam int SQ0       = 2;
   localparam int INIT      = SQ0 + SQ_STEPS;
   localparam int MD0       = INIT + 1;
   localparam int DV0       = INIT + 1;
   localparam int FOLD      = MD0 + MOD_STEPS;
   localparam int CR0       = FOLD + 1;
   localparam int PA        = CR0 + NSTEP;
   localparam int LAST      = PA + 6;
   localparam int MD_LAST   = MD0 + MOD_STEPS - 1;
   localparam int DV_LAST   = DV0 + DIV_STEPS - 1;

   typedef logic signed [15:0] s16_type;
   typedef logic signed [21:0] s22_type;
   typedef logic signed [25:0] s26_type;
   typedef logic signed [26:0] s27_type;
   typedef logic signed [27:0] s28_type;
   typedef logic signed [31:0] s32_type;
   typedef logic signed [32:0] s33_type;
   typedef logic signed [33:0] s34_type;
   typedef logic signed [34:0] s35_type;
   typedef logic signed [47:0] s48_type;
   typedef logic signed [55:0] s56_type;
   typedef logic signed [57:0] s58_type;
   typedef logic signed [63:0] s64_type;

   typedef struct packed {
      logic                rot;
      logic                incv;
      logic                neg;
      s16_type [2:0]       f;
      s16_type [2:0]       mag;
      s33_type [2:0]       pinc;
      logic [2:0][30:0]    fsq;
      s22_type [2:0]       v;
      logic [63:0]         sq_src;
      logic [35:0]         sq_rem;
      logic [31:0]         sq_root;
      logic [54:0]         md_rem;
      logic [2:0][32:0]    dv_rem;
      logic [2:0][30:0]    dv_q;
      s35_type             z;
      s34_type             cx;
      s34_type             cy;
      s34_type             cs;
      s34_type             sn;
      s32_type [2:0]       n;
      s56_type [2:0]       pd;
      s56_type [5:0]       pc;
      s26_type             dq;
      s26_type [2:0]       cq;
      s58_type [2:0]       m;
      s64_type [2:0]       ta;
      s64_type [2:0]       tb;
      s64_type [2:0]       tc;
      s26_type [2:0]       r;
      s48_type [2:0]       rl;
      s16_type [2:0]       o;
   } pipe_type;

   localparam s35_type TWO_PI_Z  = s35_type'(TWO_PI_Q30);
   localparam s35_type PI_Z      = s35_type'(PI_Q30);
   localparam s35_type HALF_Z    = s35_type'(HALF_PI_Q30);
   localparam s35_type NHALF_Z   = -s35_type'(HALF_PI_Q30);

   logic [23:0] field_gain_ff;
   logic [15:0] relax_long_ff;
   logic [15:0] relax_trans_ff;

   logic        adv;
   logic        vld_ff [0:LAST];
   pipe_type    stg_ff [0:LAST];
   pipe_type    stg_in [0:LAST];

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         field_gain_ff  <= FIELD_GAIN_RESET;
         relax_long_ff  <= RELAX_LONG_RESET;
         relax_trans_ff <= RELAX_TRANS_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_addr)
            CSR_FIELD_GAIN:  field_gain_ff  <= csr_wdata;
            CSR_RELAX_LONG:  relax_long_ff  <= csr_wdata[15:0];
            CSR_RELAX_TRANS: relax_trans_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // pipeline moves as a whole unless the output holds a stalled transaction
   assign adv       = !vld_ff[LAST] || !rsp_stall;
   assign req_stall = !adv;
   assign rsp_valid = vld_ff[LAST];
   assign rsp_out_x = stg_ff[LAST].o[0];
   assign rsp_out_y = stg_ff[LAST].o[1];
   assign rsp_out_z = stg_ff[LAST].o[2];

   // stage 0: capture and first products
   always_comb begin
      pipe_type nx0;
      s32_type  sq;
      nx0          = '0;
      nx0.f[0]     = req_field_x;
      nx0.f[1]     = req_field_y;
      nx0.f[2]     = req_field_z;
      nx0.mag[0]   = req_mag_x;
      nx0.mag[1]   = req_mag_y;
      nx0.mag[2]   = req_mag_z;
      nx0.incv     = req_incr_valid;
      nx0.pinc[0]  = req_incr_x * $signed({1'b0, req_incr_scale});
      nx0.pinc[1]  = req_incr_y * $signed({1'b0, req_incr_scale});
      nx0.pinc[2]  = req_incr_z * $signed({1'b0, req_incr_scale});
      for (int k = 0; k < 3; k++) begin
         sq         = nx0.f[k] * nx0.f[k];
         nx0.fsq[k] = sq[30:0];
      end
      stg_in[0] = nx0;
   end

   for (genvar i = 1; i <= LAST; i++) begin : g_stage
      localparam bit IS_SUM  = (i == 1);
      localparam bit IS_SQ   = (i >= SQ0) && (i < SQ0 + SQ_STEPS);
      localparam bit IS_INIT = (i == INIT);
      localparam bit IS_MOD  = (i >= MD0) && (i < MD0 + MOD_STEPS);
      localparam int MOD_SH  = IS_MOD ? (MOD_STEPS - 1 - (i - MD0)) : 0;
      localparam bit IS_DIV  = (i >= DV0) && (i < DV0 + DIV_STEPS);
      localparam int DIV_BIT = IS_DIV ? (DIV_STEPS - 1 - (i - DV0)) : 0;
      localparam bit IS_FOLD = (i == FOLD);
      localparam bit IS_CRD  = (i >= CR0) && (i < CR0 + NSTEP);
      localparam int CRD_I   = IS_CRD ? (i - CR0) : 0;
      localparam bit IS_PA   = (i == PA);
      localparam bit IS_PB   = (i == PA + 1);
      localparam bit IS_PC   = (i == PA + 2);
      localparam bit IS_PD   = (i == PA + 3);
      localparam bit IS_PE   = (i == PA + 4);
      localparam bit IS_PF   = (i == PA + 5);
      localparam bit IS_PG   = (i == PA + 6);

      pipe_type          nx;
      pipe_type          pv;
      logic [31:0]       sum32;
      logic [35:0]       sq_try;
      logic [35:0]       sq_trial;
      logic [55:0]       psi;
      logic [2:0][16:0]  fa;
      logic [54:0]       md_cand;
      logic [2:0][32:0]  dv_try;
      s35_type           fz;
      s34_type           dx;
      s34_type           dy;
      s32_type [2:0]     qs;
      s58_type           dot;
      s58_type [2:0]     crs;
      s35_type           omc;
      s28_type [2:0]     t1;
      s64_type [2:0]     tsum;
      logic signed [16:0] tfs;
      logic signed [16:0] lfs;
      s27_type           dz;
      s48_type [2:0]     rnd;

      always_comb begin
         pv       = stg_ff[i-1];
         nx       = pv;
         sum32    = '0;
         sq_try   = '0;
         sq_trial = '0;
         psi      = '0;
         fa       = '0;
         md_cand  = '0;
         dv_try   = '0;
         fz       = '0;
         dx       = '0;
         dy       = '0;
         qs       = '0;
         dot      = '0;
         crs      = '0;
         omc      = '0;
         t1       = '0;
         tsum     = '0;
         tfs      = $signed({1'b0, relax_trans_ff});
         lfs      = $signed({1'b0, relax_long_ff});
         dz       = '0;
         rnd      = '0;

         if (IS_SUM) begin
            sum32 = 32'(pv.fsq[0]) + 32'(pv.fsq[1]) + 32'(pv.fsq[2]);
            nx.sq_src  = {sum32, 32'd0};
            nx.sq_rem  = '0;
            nx.sq_root = '0;
            for (int k = 0; k < 3; k++) begin
               if (pv.incv) begin
                  nx.v[k] = s22_type'(pv.mag[k]) + s22_type'(pv.pinc[k] >>> 12);
               end else begin
                  nx.v[k] = s22_type'(pv.mag[k]);
               end
            end
         end

         // one root bit per stage
         if (IS_SQ) begin
            sq_try   = {pv.sq_rem[33:0], pv.sq_src[63:62]};
            sq_trial = {2'b00, pv.sq_root, 2'b01};
            if (sq_try >= sq_trial) begin
               nx.sq_rem  = sq_try - sq_trial;
               nx.sq_root = {pv.sq_root[30:0], 1'b1};
            end else begin
               nx.sq_rem  = sq_try;
               nx.sq_root = {pv.sq_root[30:0], 1'b0};
            end
            nx.sq_src = {pv.sq_src[61:0], 2'b00};
         end

         if (IS_INIT) begin
            psi       = 56'(field_gain_ff) * 56'(pv.sq_root);
            nx.md_rem = {1'b0, psi[55:2]};
            nx.rot    = (psi != '0);
            for (int k = 0; k < 3; k++) begin
               fa[k] = pv.f[k][15] ? (17'd0 - {pv.f[k][15], pv.f[k]}) : {1'b0, pv.f[k]};
               nx.dv_rem[k] = {1'b0, fa[k], 15'd0};
               nx.dv_q[k]   = '0;
            end
         end

         if (IS_MOD) begin
            md_cand = 55'(TWO_PI_Q30) << MOD_SH;
            if (pv.md_rem >= md_cand) begin
               nx.md_rem = pv.md_rem - md_cand;
            end
         end

         // direction components, one quotient bit per stage
         if (IS_DIV) begin
            for (int k = 0; k < 3; k++) begin
               dv_try[k] = {pv.dv_rem[k][31:0], 1'b0};
               if (dv_try[k] >= {1'b0, pv.sq_root}) begin
                  nx.dv_rem[k]          = dv_try[k] - {1'b0, pv.sq_root};
                  nx.dv_q[k][DIV_BIT]   = 1'b1;
               end else begin
                  nx.dv_rem[k] = dv_try[k];
               end
            end
         end

         // fold the angle into [-pi/2, pi/2]
         if (IS_FOLD) begin
            fz = $signed({2'b00, pv.md_rem[32:0]});
            if (fz > PI_Z) begin
               fz = fz - TWO_PI_Z;
            end
            nx.neg = 1'b0;
            if (fz > HALF_Z) begin
               fz     = fz - PI_Z;
               nx.neg = 1'b1;
            end else if (fz < NHALF_Z) begin
               fz     = fz + PI_Z;
               nx.neg = 1'b1;
            end
            nx.z  = fz;
            nx.cx = s34_type'(CORDIC_K_Q30);
            nx.cy = '0;
         end

         if (IS_CRD) begin
            dx = pv.cy >>> CRD_I;
            dy = pv.cx >>> CRD_I;
            if (!pv.z[34]) begin
               nx.cx = pv.cx - dx;
               nx.cy = pv.cy + dy;
               nx.z  = pv.z - s35_type'(atan_q30(5'(CRD_I)));
            end else begin
               nx.cx = pv.cx + dx;
               nx.cy = pv.cy - dy;
               nx.z  = pv.z + s35_type'(atan_q30(5'(CRD_I)));
            end
         end

         if (IS_PA) begin
            nx.cs = pv.neg ? -pv.cx : pv.cx;
            nx.sn = pv.neg ? -pv.cy : pv.cy;
            for (int k = 0; k < 3; k++) begin
               qs[k]   = $signed({1'b0, pv.dv_q[k]});
               nx.n[k] = pv.f[k][15] ? -qs[k] : qs[k];
               nx.pd[k] = nx.n[k] * pv.v[k];
            end
            nx.pc[0] = pv.v[1] * nx.n[2];
            nx.pc[1] = pv.v[2] * nx.n[1];
            nx.pc[2] = pv.v[2] * nx.n[0];
            nx.pc[3] = pv.v[0] * nx.n[2];
            nx.pc[4] = pv.v[0] * nx.n[1];
            nx.pc[5] = pv.v[1] * nx.n[0];
         end

         if (IS_PB) begin
            dot   = s58_type'(pv.pd[0]) + s58_type'(pv.pd[1]) + s58_type'(pv.pd[2]);
            nx.dq = s26_type'(dot >>> 30);
            for (int k = 0; k < 3; k++) begin
               crs[k]   = s58_type'(pv.pc[2*k]) - s58_type'(pv.pc[2*k+1]);
               nx.cq[k] = s26_type'(crs[k] >>> 30);
            end
         end

         if (IS_PC) begin
            for (int k = 0; k < 3; k++) begin
               nx.m[k] = pv.n[k] * pv.dq;
            end
         end

         if (IS_PD) begin
            omc = s35_type'(Q30_ONE) - s35_type'(pv.cs);
            for (int k = 0; k < 3; k++) begin
               t1[k]    = s28_type'(pv.m[k] >>> 30);
               nx.ta[k] = pv.v[k] * pv.cs;
               nx.tb[k] = pv.cq[k] * pv.sn;
               nx.tc[k] = t1[k] * omc;
            end
         end

         if (IS_PE) begin
            for (int k = 0; k < 3; k++) begin
               tsum[k] = pv.ta[k] + pv.tb[k] + pv.tc[k] + 64'sd536870912;
               if (pv.rot) begin
                  nx.r[k] = s26_type'(tsum[k] >>> 30);
               end else begin
                  nx.r[k] = s26_type'(pv.v[k]);
               end
            end
         end

         if (IS_PF) begin
            dz       = s27_type'(16384) - s27_type'(pv.r[2]);
            nx.rl[0] = pv.r[0] * tfs;
            nx.rl[1] = pv.r[1] * tfs;
            nx.rl[2] = dz * lfs;
         end

         if (IS_PG) begin
            for (int k = 0; k < 3; k++) begin
               rnd[k] = (pv.rl[k] + 48'sd16384) >>> 15;
            end
            nx.o[0] = sat16(rnd[0]);
            nx.o[1] = sat16(rnd[1]);
            nx.o[2] = sat16(s48_type'(pv.r[2]) + rnd[2]);
         end
      end

      assign stg_in[i] = nx;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= LAST; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= req_valid;
         for (int i = 1; i <= LAST; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i <= LAST; i++) begin
            stg_ff[i] <= stg_in[i];
         end
      end
   end

   // accepted transaction always lands in the first stage
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> vld_ff[0])
      else $error("accepted transaction missing from first stage");

   // reduced angle is below 2*pi
   assert property (@(posedge clock) disable iff (reset)
      vld_ff[MD_LAST] |-> (stg_ff[MD_LAST].md_rem < 55'(TWO_PI_Q30)))
      else $error("angle reduction out of range");

   // division remainders stay below the field magnitude
   assert property (@(posedge clock) disable iff (reset)
      (vld_ff[DV_LAST] && (stg_ff[DV_LAST].sq_root != '0)) |->
         ((stg_ff[DV_LAST].dv_rem[0] < {1'b0, stg_ff[DV_LAST].sq_root}) &&
          (stg_ff[DV_LAST].dv_rem[1] < {1'b0, stg_ff[DV_LAST].sq_root}) &&
          (stg_ff[DV_LAST].dv_rem[2] < {1'b0, stg_ff[DV_LAST].sq_root})))
      else $error("direction divider remainder not reduced");

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for bloch_rotation_relaxation_step. Drives random and
// edge-case spin transactions under varying idle/stall pressure, predicts
// each rotated and relaxed vector in fixed point, and compares responses
// in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench
   import brrs_pkg::*;
();

   localparam int  N_STEPS     = CORDIC_STEPS_DEFAULT;
   localparam int  PHASE_ITEMS = 160;
   localparam int  N_PHASES    = 8;
   localparam int  CYCLE_LIMIT = 300000;
   localparam int  DRAIN_WAIT  = 120;
   localparam longint TWO_PI_L  = TWO_PI_Q30;
   localparam longint PI_L      = PI_Q30;
   localparam longint HALF_PI_L = HALF_PI_Q30;
   localparam longint K_L       = CORDIC_K_Q30;
   localparam longint ONE_L     = Q30_ONE;

   typedef struct {
      logic signed [15:0] field_x, field_y, field_z;
      logic signed [15:0] mag_x, mag_y, mag_z;
      logic               incr_valid;
      logic signed [15:0] incr_x, incr_y, incr_z;
      logic        [15:0] incr_scale;
   } spin_type;

   typedef struct {
      logic signed [15:0] x, y, z;
   } vec_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [15:0] req_field_x = '0, req_field_y = '0, req_field_z = '0;
   logic signed [15:0] req_mag_x = '0, req_mag_y = '0, req_mag_z = '0;
   logic req_incr_valid = 1'b0;
   logic signed [15:0] req_incr_x = '0, req_incr_y = '0, req_incr_z = '0;
   logic [15:0] req_incr_scale = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [15:0] rsp_out_x, rsp_out_y, rsp_out_z;
   logic csr_wr_en = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   bloch_rotation_relaxation_step u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_field_x(req_field_x), .req_field_y(req_field_y), .req_field_z(req_field_z),
      .req_mag_x(req_mag_x), .req_mag_y(req_mag_y), .req_mag_z(req_mag_z),
      .req_incr_valid(req_incr_valid),
      .req_incr_x(req_incr_x), .req_incr_y(req_incr_y), .req_incr_z(req_incr_z),
      .req_incr_scale(req_incr_scale),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_out_x(rsp_out_x), .rsp_out_y(rsp_out_y), .rsp_out_z(rsp_out_z),
      .csr_wr_en(csr_wr_en), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // register shadow
   longint unsigned gain_q = FIELD_GAIN_RESET;
   longint          long_q = RELAX_LONG_RESET;
   longint          trans_q = RELAX_TRANS_RESET;

   spin_type  pending_spins[$];
   vec_type   expected_vecs[$];
   spin_type  spin_on_bus;
   int     send_idle_pct = 0;
   int     stall_pct = 0;
   int     mismatches = 0;
   int     cycles = 0;

   longint atan_tab[24] = '{
      843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
      16775850, 8388437, 4194282, 2097149, 1048575, 524287,
      262143, 131071, 65535, 32767, 16383, 8191,
      4095, 2047, 1023, 511, 255, 127};

   function automatic logic signed [15:0] clamp16(longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
   endfunction

   function automatic vec_type rotate_relax(spin_type s);
      longint f[3], v[3], n[3], cq[3], r[3];
      longint incr[3];
      longint cs, sn, dot, dq, omc, fm, t, z, x, y, dx, dy, sc, o0, o1, o2;
      longint unsigned sum, rem, root, bitv, fmag, psi;
      bit neg;
      vec_type res;
      f[0] = s.field_x; f[1] = s.field_y; f[2] = s.field_z;
      v[0] = s.mag_x;   v[1] = s.mag_y;   v[2] = s.mag_z;
      incr[0] = s.incr_x; incr[1] = s.incr_y; incr[2] = s.incr_z;
      sc = s.incr_scale;
      if (s.incr_valid) begin
         for (int k = 0; k < 3; k++) v[k] += (incr[k] * sc) >>> 12;
      end
      sum = f[0] * f[0] + f[1] * f[1] + f[2] * f[2];
      // bitwise integer square root of sum * 2^32
      rem = sum << 32;
      root = 0;
      bitv = 64'h1 << 62;
      while (bitv > rem) bitv >>= 2;
      while (bitv != 0) begin
         if (rem >= root + bitv) begin
            rem -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      fmag = root;
      psi = gain_q * fmag;
      if (psi != 0) begin
         z = (psi >> 2) % longint'(TWO_PI_L);
         neg = 1'b0;
         if (z > PI_L) z -= TWO_PI_L;
         if (z > HALF_PI_L) begin
            z -= PI_L;
            neg = 1'b1;
         end else if (z < -HALF_PI_L) begin
            z += PI_L;
            neg = 1'b1;
         end
         x = K_L;
         y = 0;
         for (int i = 0; i < N_STEPS && i < 24; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x -= dx; y += dy; z -= atan_tab[i];
            end else begin
               x += dx; y -= dy; z += atan_tab[i];
            end
         end
         cs = neg ? -x : x;
         sn = neg ? -y : y;
         fm = fmag;
         for (int k = 0; k < 3; k++) n[k] = (f[k] <<< 46) / fm;
         dot = n[0] * v[0] + n[1] * v[1] + n[2] * v[2];
         dq = dot >>> 30;
         cq[0] = (v[1] * n[2] - v[2] * n[1]) >>> 30;
         cq[1] = (v[2] * n[0] - v[0] * n[2]) >>> 30;
         cq[2] = (v[0] * n[1] - v[1] * n[0]) >>> 30;
         omc = ONE_L - cs;
         for (int k = 0; k < 3; k++) begin
            t = v[k] * cs + cq[k] * sn + ((n[k] * dq) >>> 30) * omc;
            r[k] = (t + (64'sd1 <<< 29)) >>> 30;
         end
      end else begin
         for (int k = 0; k < 3; k++) r[k] = v[k];
      end
      o0 = (r[0] * trans_q + 16384) >>> 15;
      o1 = (r[1] * trans_q + 16384) >>> 15;
      o2 = r[2] + (((16384 - r[2]) * long_q + 16384) >>> 15);
      res.x = clamp16(o0);
      res.y = clamp16(o1);
      res.z = clamp16(o2);
      return res;
   endfunction

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) expected_vecs.push_back(rotate_relax(spin_on_bus));
         if (pending_spins.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            spin_on_bus = pending_spins.pop_front();
            req_valid      <= 1'b1;
            req_field_x    <= spin_on_bus.field_x;
            req_field_y    <= spin_on_bus.field_y;
            req_field_z    <= spin_on_bus.field_z;
            req_mag_x      <= spin_on_bus.mag_x;
            req_mag_y      <= spin_on_bus.mag_y;
            req_mag_z      <= spin_on_bus.mag_z;
            req_incr_valid <= spin_on_bus.incr_valid;
            req_incr_x     <= spin_on_bus.incr_x;
            req_incr_y     <= spin_on_bus.incr_y;
            req_incr_z     <= spin_on_bus.incr_z;
            req_incr_scale <= spin_on_bus.incr_scale;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < stall_pct);
   end

   // response checker
   always @(posedge clock) begin
      vec_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_vecs.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected transaction: x=%0d y=%0d z=%0d",
                        rsp_out_x, rsp_out_y, rsp_out_z);
         end else begin
            want = expected_vecs.pop_front();
            if (rsp_out_x !== want.x || rsp_out_y !== want.y || rsp_out_z !== want.z) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected (%0d %0d %0d) got (%0d %0d %0d)",
                           want.x, want.y, want.z, rsp_out_x, rsp_out_y, rsp_out_z);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL bloch_rotation_relaxation_step");
         $finish;
      end
   end

   task automatic csr_write(csr_addr_type idx, logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      unique case (idx)
         CSR_FIELD_GAIN:  gain_q  = val;
         CSR_RELAX_LONG:  long_q  = val[15:0];
         CSR_RELAX_TRANS: trans_q = val[15:0];
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_spins.size() > 0 || req_valid || expected_vecs.size() > 0);
   endtask

   task automatic add_spin(int fx, int fy, int fz, int mx, int my, int mz,
                           bit iv, int ix, int iy, int iz, int sc);
      spin_type s;
      s.field_x = 16'(fx); s.field_y = 16'(fy); s.field_z = 16'(fz);
      s.mag_x = 16'(mx); s.mag_y = 16'(my); s.mag_z = 16'(mz);
      s.incr_valid = iv;
      s.incr_x = 16'(ix); s.incr_y = 16'(iy); s.incr_z = 16'(iz);
      s.incr_scale = 16'(sc);
      pending_spins.push_back(s);
   endtask

   function automatic logic [15:0] pick16(int style);
      int extremes[5] = '{-32768, 32767, 0, -1, 1};
      case (style)
         0:       return 16'(int'($urandom_range(32768)) - 16384);
         1:       return 16'(extremes[$urandom_range(4)]);
         2:       return 16'(int'($urandom_range(4000)) - 2000);
         default: return 16'($urandom());
      endcase
   endfunction

   function automatic spin_type random_spin();
      spin_type s;
      int    mode;
      mode = $urandom_range(9);
      s.field_x = pick16(mode < 4 ? 2 : (mode < 6 ? 3 : 1));
      s.field_y = pick16(mode < 4 ? 2 : (mode < 6 ? 3 : 1));
      s.field_z = pick16(mode < 4 ? 2 : (mode < 6 ? 3 : 1));
      // zero field now and then
      if (mode == 9) begin
         s.field_x = 0; s.field_y = 0; s.field_z = 0;
      end
      s.mag_x = pick16(mode < 5 ? 0 : (mode < 8 ? 3 : 1));
      s.mag_y = pick16(mode < 5 ? 0 : (mode < 8 ? 3 : 1));
      s.mag_z = pick16(mode < 5 ? 0 : (mode < 8 ? 3 : 1));
      s.incr_valid = 1'($urandom_range(1));
      s.incr_x = pick16(mode < 5 ? 2 : 3);
      s.incr_y = pick16(mode < 5 ? 2 : 3);
      s.incr_z = pick16(mode < 5 ? 2 : 3);
      s.incr_scale = (mode < 5) ? 16'($urandom_range(8192)) : 16'($urandom_range(65535));
      return s;
   endfunction

   int gains[N_PHASES]  = '{65536, 0, 16777215, 1200, 300000, 65536, 11184810, 5592405};
   int longs[N_PHASES]  = '{0, 32768, 32768, 1000, 16384, 65535, 0, 20000};
   int transes[N_PHASES] = '{32768, 0, 32768, 30000, 65535, 32000, 21845, 43690};

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (int ph = 0; ph < N_PHASES; ph++) begin
         wait_drained();
         repeat (DRAIN_WAIT) @(posedge clock);
         csr_write(CSR_FIELD_GAIN, CSR_DATA_W'(gains[ph]));
         csr_write(CSR_RELAX_LONG, CSR_DATA_W'(longs[ph]));
         csr_write(CSR_RELAX_TRANS, CSR_DATA_W'(transes[ph]));
         case (ph % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 60; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 60; end
            default: begin send_idle_pct = 10; stall_pct = 10; end
         endcase
         if (ph == 0) begin
            add_spin(0, 0, 0, 16384, -16384, 0, 0, 0, 0, 0, 0);
            add_spin(0, 0, 0, 100, 200, 300, 1, 32767, -32768, 1, 65535);
            add_spin(0, 0, 0, 0, 0, 0, 0, -1, -1, -1, 65535);
            add_spin(32767, 32767, 32767, 32767, 32767, 32767, 1, 32767, 32767, 32767, 65535);
            add_spin(-32768, -32768, -32768, -32768, -32768, -32768, 1,
                     -32768, -32768, -32768, 65535);
            add_spin(-32768, 0, 0, 16384, 0, 0, 0, 0, 0, 0, 0);
            add_spin(0, 32767, 0, 0, 0, 16384, 0, 0, 0, 0, 0);
            add_spin(0, 0, 1, 16384, 0, 0, 0, 0, 0, 0, 0);
            add_spin(1, 0, 0, 0, 16384, 0, 1, 16384, 0, 0, 4096);
            add_spin(25, 25, 25, 0, 0, 16384, 1, -16384, 0, 0, 4096);
            add_spin(300, -400, 500, 8000, -9000, 10000, 0, 12345, -321, 77, 999);
            add_spin(-1, -1, -1, -1, -1, -1, 1, -1, -1, -1, 1);
            add_spin(1608, 0, 0, 0, 16384, 0, 0, 0, 0, 0, 0);
            add_spin(3217, 0, 0, 0, 16384, 0, 0, 0, 0, 0, 0);
            add_spin(0, 0, 6434, 16384, 0, 0, 0, 0, 0, 0, 0);
            add_spin(1234, -5678, 32767, -32768, 32767, -32768, 1, 32767, 32767, 32767, 65535);
         end
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // midway through phase 2, new spins are queued only once the pipeline has emptied
            if (ph == 2 && i == PHASE_ITEMS / 2) wait_drained();
            pending_spins.push_back(random_spin());
         end
      end

      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS bloch_rotation_relaxation_step");
      end else begin
         $display("FAIL bloch_rotation_relaxation_step");
      end
      $finish;
   end

endmodule

FILE: filelist.f
design/brrs_pkg.sv
design/bloch_rotation_relaxation_step.sv
bench/testbench.sv
